### src/btcm_pkg.sv
// Shared action codes, field widths and controller/datapath interface types.
package btcm_pkg;

	localparam int ACT_W = 3;
	localparam int OFF_W = 16;
	localparam int REQ_W = 17;
	localparam int HEAP_W = 17;
	localparam logic [HEAP_W-1:0] HEAP_RESET = 17'd65536;

	localparam logic [ACT_W-1:0] ACT_INIT     = 3'd0;
	localparam logic [ACT_W-1:0] ACT_SPLIT    = 3'd1;
	localparam logic [ACT_W-1:0] ACT_FREE     = 3'd2;
	localparam logic [ACT_W-1:0] ACT_USED     = 3'd3;
	localparam logic [ACT_W-1:0] ACT_COALESCE = 3'd4;
	localparam logic [ACT_W-1:0] ACT_CHECK    = 3'd5;
	localparam logic [ACT_W-1:0] ACT_READ     = 3'd6;
	localparam logic [ACT_W-1:0] ACT_RSVD     = 3'd7;

	localparam int OP_W = 5;
	localparam logic [OP_W-1:0] OP_NOP     = 5'd0;
	localparam logic [OP_W-1:0] OP_LOAD    = 5'd1;
	localparam logic [OP_W-1:0] OP_WR_INIT = 5'd2;
	localparam logic [OP_W-1:0] OP_RD_G    = 5'd3;
	localparam logic [OP_W-1:0] OP_RD_AUX  = 5'd4;
	localparam logic [OP_W-1:0] OP_LAT_CUR = 5'd5;
	localparam logic [OP_W-1:0] OP_LAT_AUX = 5'd6;
	localparam logic [OP_W-1:0] OP_SP_W1   = 5'd7;
	localparam logic [OP_W-1:0] OP_SP_W2   = 5'd8;
	localparam logic [OP_W-1:0] OP_FIX_W   = 5'd9;
	localparam logic [OP_W-1:0] OP_MARK    = 5'd10;
	localparam logic [OP_W-1:0] OP_CO_NX   = 5'd11;
	localparam logic [OP_W-1:0] OP_CO_MN   = 5'd12;
	localparam logic [OP_W-1:0] OP_CO_BK   = 5'd13;
	localparam logic [OP_W-1:0] OP_CO_MP   = 5'd14;
	localparam logic [OP_W-1:0] OP_CO_FIX  = 5'd15;
	localparam logic [OP_W-1:0] OP_CK_INIT = 5'd16;
	localparam logic [OP_W-1:0] OP_CK_HIT  = 5'd17;
	localparam logic [OP_W-1:0] OP_CK_STEP = 5'd18;

	typedef struct packed {
		logic [OP_W-1:0] op;
	} btcm_cmd_t;

	typedef struct packed {
		logic [ACT_W-1:0] act;
		logic split_ok;
		logic s2_next_on;
		logic aux_in;
		logic nx_ok;
		logic aux_free;
		logic pv_ok;
		logic merged;
		logic fix_on;
		logic aligned;
		logic aux_on;
		logic aux_is_g;
		logic rd_zero;
	} btcm_sts_t;

endpackage

### src/btcm_ram.sv
// Generic single-port RAM with registered read data.
module btcm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;
endmodule

### src/btcm_ctrl.sv
// Sequencer for header actions: issues one datapath operation per cycle.
module btcm_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [btcm_pkg::ACT_W-1:0]  action,
	input  btcm_pkg::btcm_sts_t         sts,
	output btcm_pkg::btcm_cmd_t         cmd,
	output logic                        busy,
	output logic                        done
);
	import btcm_pkg::*;

	localparam logic [4:0] ST_IDLE    = 5'd0;
	localparam logic [4:0] ST_INIT_W  = 5'd1;
	localparam logic [4:0] ST_RD_G    = 5'd2;
	localparam logic [4:0] ST_LAT_G   = 5'd3;
	localparam logic [4:0] ST_SP_W1   = 5'd4;
	localparam logic [4:0] ST_SP_W2   = 5'd5;
	localparam logic [4:0] ST_FX_RD   = 5'd6;
	localparam logic [4:0] ST_FX_LAT  = 5'd7;
	localparam logic [4:0] ST_FX_W    = 5'd8;
	localparam logic [4:0] ST_MARK    = 5'd9;
	localparam logic [4:0] ST_CO_NX   = 5'd10;
	localparam logic [4:0] ST_CO_RDN  = 5'd11;
	localparam logic [4:0] ST_CO_LN   = 5'd12;
	localparam logic [4:0] ST_CO_MN   = 5'd13;
	localparam logic [4:0] ST_CO_BK   = 5'd14;
	localparam logic [4:0] ST_CO_RDP  = 5'd15;
	localparam logic [4:0] ST_CO_LP   = 5'd16;
	localparam logic [4:0] ST_CO_MP   = 5'd17;
	localparam logic [4:0] ST_CO_FIX  = 5'd18;
	localparam logic [4:0] ST_CK_INIT = 5'd19;
	localparam logic [4:0] ST_CK_TEST = 5'd20;
	localparam logic [4:0] ST_CK_LAT  = 5'd21;
	localparam logic [4:0] ST_FIN_RD  = 5'd22;
	localparam logic [4:0] ST_FIN_LAT = 5'd23;
	localparam logic [4:0] ST_DONE    = 5'd24;

	logic [4:0] state_q;
	logic [4:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd.op = OP_NOP;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.op = OP_LOAD;
					state_d = (action == ACT_INIT) ? ST_INIT_W : ST_RD_G;
				end
			end
			ST_INIT_W: begin
				cmd.op = OP_WR_INIT;
				state_d = ST_FIN_RD;
			end
			ST_RD_G: begin
				cmd.op = OP_RD_G;
				state_d = ST_LAT_G;
			end
			ST_LAT_G: begin
				cmd.op = OP_LAT_CUR;
				case (sts.act)
					ACT_SPLIT:    state_d = ST_SP_W1;
					ACT_FREE:     state_d = ST_MARK;
					ACT_USED:     state_d = ST_MARK;
					ACT_COALESCE: state_d = ST_CO_NX;
					ACT_CHECK:    state_d = ST_CK_INIT;
					default:      state_d = ST_DONE;
				endcase
			end
			ST_SP_W1: begin
				if (sts.split_ok) begin
					cmd.op = OP_SP_W1;
					state_d = ST_SP_W2;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_SP_W2: begin
				cmd.op = OP_SP_W2;
				state_d = (sts.aux_in && sts.s2_next_on) ? ST_FX_RD : ST_FIN_RD;
			end
			ST_FX_RD: begin
				cmd.op = OP_RD_AUX;
				state_d = ST_FX_LAT;
			end
			ST_FX_LAT: begin
				cmd.op = OP_LAT_AUX;
				state_d = ST_FX_W;
			end
			ST_FX_W: begin
				cmd.op = OP_FIX_W;
				state_d = ST_FIN_RD;
			end
			ST_MARK: begin
				cmd.op = OP_MARK;
				state_d = ST_FIN_RD;
			end
			ST_CO_NX: begin
				cmd.op = OP_CO_NX;
				state_d = sts.nx_ok ? ST_CO_RDN : ST_CO_BK;
			end
			ST_CO_RDN: begin
				cmd.op = OP_RD_AUX;
				state_d = ST_CO_LN;
			end
			ST_CO_LN: begin
				cmd.op = OP_LAT_AUX;
				state_d = ST_CO_MN;
			end
			ST_CO_MN: begin
				if (sts.aux_free) begin
					cmd.op = OP_CO_MN;
				end
				state_d = ST_CO_BK;
			end
			ST_CO_BK: begin
				cmd.op = OP_CO_BK;
				state_d = sts.pv_ok ? ST_CO_RDP : ST_CO_FIX;
			end
			ST_CO_RDP: begin
				cmd.op = OP_RD_AUX;
				state_d = ST_CO_LP;
			end
			ST_CO_LP: begin
				cmd.op = OP_LAT_AUX;
				state_d = ST_CO_MP;
			end
			ST_CO_MP: begin
				if (sts.aux_free) begin
					cmd.op = OP_CO_MP;
				end
				state_d = ST_CO_FIX;
			end
			ST_CO_FIX: begin
				if (sts.merged) begin
					cmd.op = OP_CO_FIX;
					state_d = sts.fix_on ? ST_FX_RD : ST_FIN_RD;
				end else begin
					state_d = ST_FIN_RD;
				end
			end
			ST_CK_INIT: begin
				cmd.op = OP_CK_INIT;
				state_d = sts.aligned ? ST_CK_TEST : ST_FIN_RD;
			end
			ST_CK_TEST: begin
				if (!sts.aux_on) begin
					state_d = ST_FIN_RD;
				end else if (sts.aux_is_g) begin
					cmd.op = OP_CK_HIT;
					state_d = ST_FIN_RD;
				end else begin
					cmd.op = OP_RD_AUX;
					state_d = ST_CK_LAT;
				end
			end
			ST_CK_LAT: begin
				if (sts.rd_zero) begin
					state_d = ST_FIN_RD;
				end else begin
					cmd.op = OP_CK_STEP;
					state_d = ST_CK_TEST;
				end
			end
			ST_FIN_RD: begin
				cmd.op = OP_RD_G;
				state_d = ST_FIN_LAT;
			end
			ST_FIN_LAT: begin
				cmd.op = OP_LAT_CUR;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);

	a_done_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("controller stayed busy after result beat");
	a_start_takes: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted beat did not start work");
	a_no_strobe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !done) else $error("result strobe while idle");
endmodule

### src/btcm_datapath.sv
// Header registers, address selection, size arithmetic and the heap size register.
module btcm_datapath #(
	parameter int HEAP_MAX_BYTES = 65536,
	parameter int ALIGN_BYTES = 16,
	parameter int CHUNK_HEADER_BYTES = 16,
	parameter int HEAP_HEADER_BYTES = 32,
	parameter int AW = 12,
	parameter int WW = 27
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  btcm_pkg::btcm_cmd_t          cmd,
	output btcm_pkg::btcm_sts_t          sts,
	input  logic [btcm_pkg::ACT_W-1:0]   action,
	input  logic [btcm_pkg::OFF_W-1:0]   chunk_offset,
	input  logic [btcm_pkg::REQ_W-1:0]   request_size,
	input  logic                         cfg_wr,
	input  logic [btcm_pkg::HEAP_W-1:0]  cfg_data,
	output logic                         ram_we,
	output logic [AW-1:0]                ram_addr,
	output logic [WW-1:0]                ram_wdata,
	input  logic [WW-1:0]                ram_rdata,
	output logic [btcm_pkg::OFF_W-1:0]   result_offset,
	output logic [btcm_pkg::REQ_W-1:0]   chunk_bytes,
	output logic [btcm_pkg::REQ_W-1:0]   back_bytes,
	output logic                         is_free,
	output logic                         fits,
	output logic                         corrupt,
	output logic                         merged
);
	import btcm_pkg::*;

	localparam int GRANS = HEAP_MAX_BYTES / ALIGN_BYTES;
	localparam int AL2 = $clog2(ALIGN_BYTES);
	localparam int SW = $clog2(GRANS + 1);
	localparam int NW = $clog2(GRANS + 65536) + 1;
	localparam int CW = NW + AL2;
	localparam int HHG = HEAP_HEADER_BYTES / ALIGN_BYTES;
	localparam int HMIN = HEAP_HEADER_BYTES + ALIGN_BYTES;

	function automatic logic on_heap(input logic [NW-1:0] x, input logic [CW-1:0] h);
		logic [CW-1:0] xb;
		xb = {x, {AL2{1'b0}}};
		return (x != '0) && (xb < h);
	endfunction

	function automatic logic [SW-1:0] sat(input logic [SW:0] s);
		return (s > (SW+1)'(GRANS)) ? SW'(GRANS) : s[SW-1:0];
	endfunction

	logic [HEAP_W-1:0] heap_q;
	logic [ACT_W-1:0]  act_q;
	logic [OFF_W-1:0]  off_q;
	logic [REQ_W-1:0]  req_q;
	logic [NW-1:0]     g_q;
	logic [NW-1:0]     aux_q;
	logic [SW-1:0]     cur_sz_q, cur_bk_q, aux_sz_q, aux_bk_q, fix_q;
	logic              cur_fr_q, aux_fr_q;
	logic              merged_q, corrupt_q, rd_ok_q;

	logic [CW-1:0] h_eff;
	logic [NW-1:0] rq, rest_n, nx_cur, pv, s2_next;
	logic [SW-1:0] rest, sum_sz, rd_sz, init_sz;
	logic          rd_fr;
	logic [SW-1:0] rd_bk;
	logic          g_in, aux_in;
	logic          use_aux, wr_op;

	always_comb begin
		h_eff = CW'(heap_q);
		if (h_eff > CW'(HEAP_MAX_BYTES)) begin
			h_eff = CW'(HEAP_MAX_BYTES);
		end
		if (h_eff < CW'(HMIN)) begin
			h_eff = CW'(HMIN);
		end
	end

	assign init_sz = SW'((h_eff - CW'(HEAP_HEADER_BYTES)) >> AL2);
	assign rq      = NW'(req_q >> AL2);
	assign rest    = cur_sz_q - rq[SW-1:0];
	assign rest_n  = NW'(rest);
	assign nx_cur  = g_q + NW'(cur_sz_q);
	assign pv      = g_q - NW'(cur_bk_q);
	assign s2_next = aux_q + rest_n;
	assign sum_sz  = sat({1'b0, cur_sz_q} + {1'b0, aux_sz_q});
	assign g_in    = (g_q < NW'(GRANS));
	assign aux_in  = (aux_q < NW'(GRANS));

	// out-of-storage reads answer zero
	assign rd_sz = rd_ok_q ? ram_rdata[WW-1 -: SW] : '0;
	assign rd_fr = rd_ok_q ? ram_rdata[SW] : 1'b0;
	assign rd_bk = rd_ok_q ? ram_rdata[SW-1:0] : '0;

	always_comb begin
		sts.act        = act_q;
		sts.split_ok   = (rq != '0) && (rq <= NW'(cur_sz_q))
			&& (CW'({rest, {AL2{1'b0}}}) > CW'(CHUNK_HEADER_BYTES));
		sts.s2_next_on = on_heap(s2_next, h_eff);
		sts.aux_in     = aux_in;
		sts.nx_ok      = on_heap(nx_cur, h_eff) && (cur_sz_q != '0);
		sts.aux_free   = aux_fr_q;
		sts.pv_ok      = (NW'(cur_bk_q) <= g_q) && on_heap(pv, h_eff) && (cur_bk_q != '0);
		sts.merged     = merged_q;
		sts.fix_on     = on_heap(nx_cur, h_eff);
		sts.aligned    = (off_q[AL2-1:0] == '0);
		sts.aux_on     = on_heap(aux_q, h_eff);
		sts.aux_is_g   = (aux_q == g_q);
		sts.rd_zero    = (rd_sz == '0);
	end

	always_comb begin
		use_aux = 1'b1;
		wr_op = 1'b0;
		ram_wdata = {cur_sz_q, cur_fr_q, cur_bk_q};
		case (cmd.op)
			OP_WR_INIT: begin
				use_aux = 1'b0;
				wr_op = 1'b1;
				ram_wdata = {init_sz, 1'b0, {SW{1'b0}}};
			end
			OP_RD_G, OP_LAT_CUR: begin
				use_aux = 1'b0;
			end
			OP_SP_W1: begin
				use_aux = 1'b0;
				wr_op = 1'b1;
				ram_wdata = {rq[SW-1:0], 1'b1, cur_bk_q};
			end
			OP_SP_W2: begin
				wr_op = 1'b1;
				ram_wdata = {rest, 1'b1, rq[SW-1:0]};
			end
			OP_FIX_W: begin
				wr_op = 1'b1;
				ram_wdata = {aux_sz_q, aux_fr_q, fix_q};
			end
			OP_MARK: begin
				use_aux = 1'b0;
				wr_op = 1'b1;
				ram_wdata = {cur_sz_q, (act_q == ACT_FREE), cur_bk_q};
			end
			OP_CO_MN: begin
				use_aux = 1'b0;
				wr_op = 1'b1;
				ram_wdata = {sum_sz, cur_fr_q, cur_bk_q};
			end
			OP_CO_MP: begin
				wr_op = 1'b1;
				ram_wdata = {sum_sz, aux_fr_q, aux_bk_q};
			end
			default: begin
				use_aux = 1'b1;
			end
		endcase
	end

	assign ram_addr = use_aux ? aux_q[AW-1:0] : g_q[AW-1:0];
	// drop writes beyond storage
	assign ram_we = wr_op && (use_aux ? aux_in : g_in);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_q    <= HEAP_RESET;
			merged_q  <= 1'b0;
			corrupt_q <= 1'b0;
			act_q     <= ACT_READ;
		end else begin
			if (cfg_wr) begin
				heap_q <= cfg_data;
			end
			case (cmd.op)
				OP_LOAD: begin
					act_q     <= action;
					merged_q  <= 1'b0;
					corrupt_q <= 1'b0;
				end
				OP_SP_W1, OP_CO_MN, OP_CO_MP: merged_q <= 1'b1;
				OP_CK_INIT: corrupt_q <= 1'b1;
				OP_CK_HIT:  corrupt_q <= 1'b0;
				default: begin
					merged_q <= merged_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				off_q <= chunk_offset;
				req_q <= request_size;
				g_q   <= (action == ACT_INIT) ? NW'(HHG) : NW'(chunk_offset >> AL2);
			end
			OP_RD_G:   rd_ok_q <= g_in;
			OP_RD_AUX: rd_ok_q <= aux_in;
			OP_LAT_CUR: begin
				cur_sz_q <= rd_sz;
				cur_fr_q <= rd_fr;
				cur_bk_q <= rd_bk;
			end
			OP_LAT_AUX: begin
				aux_sz_q <= rd_sz;
				aux_fr_q <= rd_fr;
				aux_bk_q <= rd_bk;
			end
			OP_SP_W1: aux_q <= g_q + rq;
			OP_SP_W2: begin
				aux_q <= s2_next;
				fix_q <= rest;
			end
			OP_CO_NX: aux_q <= nx_cur;
			OP_CO_MN: cur_sz_q <= sum_sz;
			OP_CO_BK: aux_q <= pv;
			OP_CO_MP: begin
				g_q      <= aux_q;
				cur_sz_q <= sum_sz;
				cur_fr_q <= aux_fr_q;
				cur_bk_q <= aux_bk_q;
			end
			OP_CO_FIX: begin
				aux_q <= nx_cur;
				fix_q <= cur_sz_q;
			end
			OP_CK_INIT: aux_q <= NW'(HHG);
			OP_CK_STEP: aux_q <= aux_q + NW'(rd_sz);
			default: begin
				aux_q <= aux_q;
			end
		endcase
	end

	logic [CW-1:0] g_b, sz_b, bk_b;
	assign g_b  = {g_q, {AL2{1'b0}}};
	assign sz_b = CW'({cur_sz_q, {AL2{1'b0}}});
	assign bk_b = CW'({cur_bk_q, {AL2{1'b0}}});

	assign result_offset = g_b[OFF_W-1:0];
	assign chunk_bytes   = sz_b[REQ_W-1:0];
	assign back_bytes    = bk_b[REQ_W-1:0];
	assign is_free       = cur_fr_q;
	assign fits          = cur_fr_q && (CW'(req_q) <= sz_b);
	assign corrupt       = corrupt_q;
	assign merged        = merged_q;

	a_corrupt_check_only: assert property (@(posedge clk) disable iff (!arst_n)
		corrupt_q |-> (act_q == ACT_CHECK)) else $error("corrupt flag outside check");
	a_merged_only: assert property (@(posedge clk) disable iff (!arst_n)
		merged_q |-> (act_q == ACT_SPLIT || act_q == ACT_COALESCE))
		else $error("merged flag outside split or coalesce");
	a_no_write_load: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_LOAD) |-> !ram_we) else $error("header write while loading beat");
endmodule

### src/boundary_tag_chunk_manager_core.sv
// Top level of the boundary-tag chunk header manager.
// One action per beat on start/busy; the result beat appears on the result ports for one
// cycle with done high and must be taken then. All headers live in one single-port RAM
// with registered read, so every header read is an address step followed by a latch step.
// Check walks the chunk chain from the heap header, so its length follows the number of
// chunks ahead of the offset; an unaligned offset ends it without a walk. The heap size
// register can be written whenever the block is idle; the header memory holds no reset
// value and needs an init before use.
module boundary_tag_chunk_manager_core #(
	parameter int HEAP_MAX_BYTES = 65536,
	parameter int ALIGN_BYTES = 16,
	parameter int CHUNK_HEADER_BYTES = 16,
	parameter int HEAP_HEADER_BYTES = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [btcm_pkg::ACT_W-1:0]   action,
	input  logic [btcm_pkg::OFF_W-1:0]   chunk_offset,
	input  logic [btcm_pkg::REQ_W-1:0]   request_size,
	output logic                         done,
	output logic [btcm_pkg::OFF_W-1:0]   result_offset,
	output logic [btcm_pkg::REQ_W-1:0]   chunk_bytes,
	output logic [btcm_pkg::REQ_W-1:0]   back_bytes,
	output logic                         is_free,
	output logic                         fits,
	output logic                         corrupt,
	output logic                         merged,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [btcm_pkg::HEAP_W-1:0]  cfg_data
);
	import btcm_pkg::*;

	localparam int GRANS = HEAP_MAX_BYTES / ALIGN_BYTES;
	localparam int AW = $clog2(GRANS);
	localparam int SW = $clog2(GRANS + 1);
	localparam int WW = 2 * SW + 1;

	btcm_cmd_t cmd;
	btcm_sts_t sts;
	logic          ram_we;
	logic [AW-1:0] ram_addr;
	logic [WW-1:0] ram_wdata, ram_rdata;

	assign cfg_ready = 1'b1;

	btcm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (action),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	btcm_datapath #(
		.HEAP_MAX_BYTES     (HEAP_MAX_BYTES),
		.ALIGN_BYTES        (ALIGN_BYTES),
		.CHUNK_HEADER_BYTES (CHUNK_HEADER_BYTES),
		.HEAP_HEADER_BYTES  (HEAP_HEADER_BYTES),
		.AW                 (AW),
		.WW                 (WW)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.action        (action),
		.chunk_offset  (chunk_offset),
		.request_size  (request_size),
		.cfg_wr        (cfg_valid && cfg_ready),
		.cfg_data      (cfg_data),
		.ram_we        (ram_we),
		.ram_addr      (ram_addr),
		.ram_wdata     (ram_wdata),
		.ram_rdata     (ram_rdata),
		.result_offset (result_offset),
		.chunk_bytes   (chunk_bytes),
		.back_bytes    (back_bytes),
		.is_free       (is_free),
		.fits          (fits),
		.corrupt       (corrupt),
		.merged        (merged)
	);

	btcm_ram #(
		.WIDTH (WW),
		.DEPTH (GRANS)
	) u_hdr_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);
endmodule
